// File: rtl/sgc_pkg.sv
// Shared types, constants and the exponential table function for the segment chi-square block.
package sgc_pkg;

    localparam int EXP_DEPTH_DEF = 256;
    localparam int BIN_BITS_DEF  = 20;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_START_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_BEG  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_END  = 3'd6;

    localparam int BIN_W   = 20;
    localparam int SUM_W   = 48;

    // Divider sizes: remainder holds the widest divisor, quotient the longest run.
    localparam int DIV_REM_W = 34;
    localparam int DIV_Q_W   = 48;
    localparam int DIV_CNT_W = 6;

    localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748383;

    typedef struct packed {
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic signed [23:0] light;
        logic [15:0]        light_sigma;
        logic [BIN_W-1:0]   bin_index;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [BIN_W-1:0] bin_out;
        logic [31:0]      model_value;
        logic [SUM_W-1:0] chi2_sum;
        logic             last_out;
    } t_out_item;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DIFF, ST_PROD, ST_SEL, ST_BRANCH, ST_EPS_W, ST_AMP, ST_DIST_W,
        ST_FAR, ST_IDX, ST_IDX_W, ST_LOOK, ST_MODEL, ST_ERR, ST_SQ, ST_TERM,
        ST_TERM_W, ST_OUT
    } t_state;

    typedef enum logic [4:0] {
        STEP_NONE, STEP_DIFF, STEP_PROD, STEP_SEL, STEP_EPS_GO, STEP_EPS_GET,
        STEP_AMP, STEP_DIST_GET, STEP_FAR, STEP_IDX_GO, STEP_LOOK, STEP_MODEL,
        STEP_ERR, STEP_SQ, STEP_TERM_SAT, STEP_TERM_GO, STEP_TERM_GET, STEP_OUT
    } t_step;

    typedef enum logic [1:0] {
        ZONE_BEFORE, ZONE_AFTER, ZONE_ALONG
    } t_zone;

    typedef struct packed {
        logic  accept;
        t_step step;
    } t_cmd;

    typedef struct packed {
        logic  div_done;
        t_zone zone;
        logic  far;
        logic  term_sat;
        logic  out_free;
    } t_status;

    // Entry idx of the exp(-x/16) table, built by repeated Q0.32 steps.
    function automatic logic [15:0] exp_entry(input int unsigned idx);
        logic [63:0] e;
        logic [63:0] t;
        e = 64'h1_0000_0000;
        for (int unsigned k = 0; k < idx; k++) begin
            e = (e * EXP_STEP_Q32 + 64'h8000_0000) >> 32;
        end
        t = (e + 64'd32768) >> 16;
        return (t > 64'd65535) ? 16'hFFFF : t[15:0];
    endfunction

endpackage

// File: rtl/segment_gaussian_chi2.sv
// Top level of the segment Gaussian chi-square evaluator.
//
//  channel   direction  handshake                    payload
//  in        input      i_in_valid / o_in_ready      i_in_data  (t_in_item)
//  out       output     o_out_valid / i_out_ready    o_out_data (t_out_item)
//  cfg       input      i_cfg_we                     i_cfg_idx, i_cfg_data
//
// A new pixel beat is taken only once the controller has finished the one before it. The
// shared one-bit-per-cycle divider does each division in turn: along the segment 17
// quotient bits for the position and 34 for the distance, then in every zone log2 of the
// table depth for the index and 48 for the chi-square term. A pixel past the table skips
// the index division and a saturated term skips the last one. Reset is synchronous and
// clears the running sum at once. A finished beat waits in the output register while the
// next input beat is taken; the controller stalls only when it has a new result and the
// output register is still full.
module segment_gaussian_chi2
    import sgc_pkg::*;
#(
    parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF,
    parameter int BIN_INDEX_BITS  = BIN_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    t_cmd    w_cmd;
    t_status w_status;

    sgc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    sgc_dp #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH),
        .BIN_INDEX_BITS  (BIN_INDEX_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// File: rtl/sgc_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions of the datapath.
module sgc_div
    import sgc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_REM_W-1:0] i_rem,
    input  logic [DIV_Q_W-1:0]   i_low,
    input  logic [DIV_REM_W-1:0] i_den,
    input  logic [DIV_CNT_W-1:0] i_steps,
    output logic                 o_done,
    output logic [DIV_Q_W-1:0]   o_quo
);

    logic [DIV_REM_W-1:0] r_rem;
    logic [DIV_Q_W-1:0]   r_low;
    logic [DIV_REM_W-1:0] r_den;
    logic [DIV_Q_W-1:0]   r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_REM_W:0]   w_trial;
    logic                 w_ge;
    logic [DIV_REM_W:0]   w_diff;

    assign w_trial = {r_rem, r_low[DIV_Q_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_low <= i_low;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_REM_W-1:0] : w_trial[DIV_REM_W-1:0];
            r_low <= {r_low[DIV_Q_W-2:0], 1'b0};
            r_quo <= {r_quo[DIV_Q_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// File: rtl/sgc_dp.sv
// Datapath: configuration registers, geometry, model, chi-square term and the result register.
module sgc_dp
    import sgc_pkg::*;
#(
    parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF,
    parameter int BIN_INDEX_BITS  = BIN_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_in_data,
    input  logic                  i_out_ready,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_out_valid,
    output t_out_item             o_out_data
);

    localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);

    logic signed [15:0] r_sx, r_sy, r_ex, r_ey;
    logic [15:0]        r_ws, r_sa, r_ea;

    t_in_item           r_in;
    logic signed [16:0] r_rx, r_ry, r_dx, r_dy, r_qx, r_qy;
    logic [31:0]        r_s2, r_ls2, r_a_start, r_a_end;
    logic signed [34:0] r_dot, r_cross;
    logic [33:0]        r_d2, r_dist_r, r_dist_q, r_dist2;
    logic [65:0]        r_c2;
    t_zone              r_zone;
    logic [31:0]        r_amp;
    logic [16:0]        r_eps;
    logic               r_far;
    logic [15:0]        r_e;
    logic [31:0]        r_model;
    logic [32:0]        r_diff;
    logic [65:0]        r_dd;
    logic [SUM_W-1:0]   r_term, r_acc;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [15:0]        w_ws, w_ls;
    logic signed [33:0] w_p_rdx, w_p_rdy_y, w_p_rdy, w_p_ryx;
    logic signed [33:0] w_p_dxx, w_p_dyy, w_p_rxx, w_p_ryy, w_p_qxx, w_p_qyy;
    logic               w_dot_le0, w_dot_gt;
    logic [33:0]        w_cabs;
    logic [67:0]        w_c2;
    logic [49:0]        w_amp_sum;
    logic [46:0]        w_num;
    logic [63:0]        w_lim;
    logic [47:0]        w_mp;
    logic signed [33:0] w_dif;
    logic [48:0]        w_sum;
    logic [SUM_W-1:0]   w_sum_sat;
    logic [BIN_W-1:0]   w_bin;
    logic [15:0]        w_rom [EXP_TABLE_DEPTH];
    logic [IDX_W-1:0]   w_rom_idx;

    logic                 w_div_start;
    logic [DIV_REM_W-1:0] w_div_rem, w_div_den;
    logic [DIV_Q_W-1:0]   w_div_low;
    logic [DIV_CNT_W-1:0] w_div_steps;
    logic                 w_div_done;
    logic [DIV_Q_W-1:0]   w_quo;

    for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_rom
        assign w_rom[g] = exp_entry(g);
    end

    for (genvar b = 0; b < BIN_W; b++) begin : g_bin
        assign w_bin[b] = (b < BIN_INDEX_BITS) ? r_in.bin_index[b] : 1'b0;
    end

    // A zero sigma counts as one.
    assign w_ws = (r_ws == 16'd0) ? 16'd1 : r_ws;
    assign w_ls = (r_in.light_sigma == 16'd0) ? 16'd1 : r_in.light_sigma;

    assign w_p_rdx   = r_rx * r_dx;
    assign w_p_rdy_y = r_ry * r_dy;
    assign w_p_rdy   = r_rx * r_dy;
    assign w_p_ryx   = r_ry * r_dx;
    assign w_p_dxx   = r_dx * r_dx;
    assign w_p_dyy   = r_dy * r_dy;
    assign w_p_rxx   = r_rx * r_rx;
    assign w_p_ryy   = r_ry * r_ry;
    assign w_p_qxx   = r_qx * r_qx;
    assign w_p_qyy   = r_qy * r_qy;

    assign w_dot_le0 = r_dot[34] || (r_dot == '0);
    assign w_dot_gt  = r_dot[33:0] > r_d2;
    assign w_cabs    = r_cross[34] ? 34'(-r_cross) : r_cross[33:0];
    assign w_c2      = 68'(w_cabs) * 68'(w_cabs);

    assign w_amp_sum = 50'(r_a_end) * 50'(r_eps)
                     + 50'(r_a_start) * 50'(17'h10000 - r_eps);

    assign w_num     = {r_dist2, 13'd0};
    assign w_lim     = 64'(EXP_TABLE_DEPTH) * 64'(r_s2);
    assign w_rom_idx = w_quo[IDX_W-1:0];

    assign w_mp  = 48'(r_amp) * 48'(r_e);
    assign w_dif = {2'b00, r_model} - {{10{r_in.light[23]}}, r_in.light};

    assign w_sum     = 49'(r_acc) + 49'(r_term);
    assign w_sum_sat = w_sum[48] ? {SUM_W{1'b1}} : w_sum[SUM_W-1:0];

    always_comb begin
        w_div_start = 1'b0;
        w_div_rem   = '0;
        w_div_low   = '0;
        w_div_den   = r_d2;
        w_div_steps = '0;
        case (i_cmd.step)
            STEP_EPS_GO: begin
                w_div_start = 1'b1;
                w_div_rem   = {1'b0, r_dot[33:1]};
                w_div_low   = {r_dot[0], {(DIV_Q_W-1){1'b0}}};
                w_div_steps = DIV_CNT_W'(17);
            end
            STEP_AMP: begin
                w_div_start = 1'b1;
                w_div_rem   = {2'b00, r_c2[65:34]};
                w_div_low   = {r_c2[33:0], {(DIV_Q_W-34){1'b0}}};
                w_div_steps = DIV_CNT_W'(34);
            end
            STEP_IDX_GO: begin
                w_div_start = 1'b1;
                w_div_rem   = DIV_REM_W'(w_num >> IDX_W);
                w_div_low   = DIV_Q_W'(w_num[IDX_W-1:0]) << (DIV_Q_W - IDX_W);
                w_div_den   = {2'b00, r_s2};
                w_div_steps = DIV_CNT_W'(IDX_W);
            end
            STEP_TERM_GO: begin
                w_div_start = 1'b1;
                w_div_rem   = r_dd[65:32];
                w_div_low   = {r_dd[31:0], 16'd0};
                w_div_den   = {2'b00, r_ls2};
                w_div_steps = DIV_CNT_W'(48);
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    sgc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_rem   (w_div_rem),
        .i_low   (w_div_low),
        .i_den   (w_div_den),
        .i_steps (w_div_steps),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= '0;
            r_sy <= '0;
            r_ex <= '0;
            r_ey <= '0;
            r_ws <= 16'd256;
            r_sa <= 16'd256;
            r_ea <= 16'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_X: r_sx <= i_cfg_data;
                CFG_START_Y: r_sy <= i_cfg_data;
                CFG_END_X:   r_ex <= i_cfg_data;
                CFG_END_Y:   r_ey <= i_cfg_data;
                CFG_WIDTH:   r_ws <= i_cfg_data;
                CFG_AMP_BEG: r_sa <= i_cfg_data;
                CFG_AMP_END: r_ea <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.step == STEP_OUT) begin
                r_out_valid <= 1'b1;
                r_acc       <= r_in.last ? '0 : w_sum_sat;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in <= i_in_data;
        end
        case (i_cmd.step)
            STEP_DIFF: begin
                r_rx      <= {r_in.pixel_x[15], r_in.pixel_x} - {r_sx[15], r_sx};
                r_ry      <= {r_in.pixel_y[15], r_in.pixel_y} - {r_sy[15], r_sy};
                r_dx      <= {r_ex[15], r_ex} - {r_sx[15], r_sx};
                r_dy      <= {r_ey[15], r_ey} - {r_sy[15], r_sy};
                r_qx      <= {r_in.pixel_x[15], r_in.pixel_x} - {r_ex[15], r_ex};
                r_qy      <= {r_in.pixel_y[15], r_in.pixel_y} - {r_ey[15], r_ey};
                r_s2      <= 32'(w_ws) * 32'(w_ws);
                r_ls2     <= 32'(w_ls) * 32'(w_ls);
                r_a_start <= 32'(r_sa) * 32'(r_sa);
                r_a_end   <= 32'(r_ea) * 32'(r_ea);
            end
            STEP_PROD: begin
                r_dot    <= {w_p_rdx[33], w_p_rdx} + {w_p_rdy_y[33], w_p_rdy_y};
                r_cross  <= {w_p_rdy[33], w_p_rdy} - {w_p_ryx[33], w_p_ryx};
                r_d2     <= 34'(w_p_dxx) + 34'(w_p_dyy);
                r_dist_r <= 34'(w_p_rxx) + 34'(w_p_ryy);
                r_dist_q <= 34'(w_p_qxx) + 34'(w_p_qyy);
            end
            STEP_SEL: begin
                r_c2 <= w_c2[65:0];
                if (w_dot_le0) begin
                    r_zone  <= ZONE_BEFORE;
                    r_dist2 <= r_dist_r;
                    r_amp   <= r_a_start;
                end else if (w_dot_gt) begin
                    r_zone  <= ZONE_AFTER;
                    r_dist2 <= r_dist_q;
                    r_amp   <= r_a_end;
                end else begin
                    r_zone  <= ZONE_ALONG;
                end
            end
            STEP_EPS_GET:  r_eps   <= w_quo[16:0];
            STEP_AMP:      r_amp   <= w_amp_sum[47:16];
            STEP_DIST_GET: r_dist2 <= w_quo[33:0];
            STEP_FAR:      r_far   <= 64'(w_num) >= w_lim;
            STEP_LOOK: begin
                if (r_far || (32'(w_rom_idx) >= 32'(EXP_TABLE_DEPTH))) begin
                    r_e <= '0;
                end else begin
                    r_e <= w_rom[w_rom_idx];
                end
            end
            STEP_MODEL:    r_model <= 32'(w_mp[47:24]);
            STEP_ERR:      r_diff  <= w_dif[33] ? 33'(-w_dif) : w_dif[32:0];
            STEP_SQ:       r_dd    <= 66'(r_diff) * 66'(r_diff);
            STEP_TERM_SAT: r_term  <= {SUM_W{1'b1}};
            STEP_TERM_GET: r_term  <= w_quo[SUM_W-1:0];
            STEP_OUT: begin
                r_out.bin_out     <= w_bin;
                r_out.model_value <= r_model;
                r_out.chi2_sum    <= w_sum_sat;
                r_out.last_out    <= r_in.last;
            end
            default: begin
            end
        endcase
    end

    assign o_status.div_done = w_div_done;
    assign o_status.zone     = r_zone;
    assign o_status.far      = r_far;
    assign o_status.term_sat = r_dd >= {2'b00, r_ls2, 32'd0};
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/sgc_ctrl.sv
// Controller: sequences the datapath steps for one pixel beat at a time.
module sgc_ctrl
    import sgc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_DIFF;
            ST_DIFF:   n_state = ST_PROD;
            ST_PROD:   n_state = ST_SEL;
            ST_SEL:    n_state = ST_BRANCH;
            ST_BRANCH: n_state = (i_status.zone == ZONE_ALONG) ? ST_EPS_W : ST_IDX;
            ST_EPS_W:  if (i_status.div_done) n_state = ST_AMP;
            ST_AMP:    n_state = ST_DIST_W;
            ST_DIST_W: if (i_status.div_done) n_state = ST_FAR;
            ST_FAR:    n_state = ST_IDX;
            ST_IDX:    n_state = i_status.far ? ST_LOOK : ST_IDX_W;
            ST_IDX_W:  if (i_status.div_done) n_state = ST_LOOK;
            ST_LOOK:   n_state = ST_MODEL;
            ST_MODEL:  n_state = ST_ERR;
            ST_ERR:    n_state = ST_SQ;
            ST_SQ:     n_state = ST_TERM;
            ST_TERM:   n_state = i_status.term_sat ? ST_OUT : ST_TERM_W;
            ST_TERM_W: if (i_status.div_done) n_state = ST_OUT;
            ST_OUT:    if (i_status.out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.accept = 1'b0;
        o_cmd.step   = STEP_NONE;
        o_in_ready   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_DIFF:   o_cmd.step = STEP_DIFF;
            ST_PROD:   o_cmd.step = STEP_PROD;
            ST_SEL:    o_cmd.step = STEP_SEL;
            // Off the segment the distance is already known, so go straight to the range check.
            ST_BRANCH: o_cmd.step = (i_status.zone == ZONE_ALONG) ? STEP_EPS_GO : STEP_FAR;
            ST_EPS_W:  if (i_status.div_done) o_cmd.step = STEP_EPS_GET;
            ST_AMP:    o_cmd.step = STEP_AMP;
            ST_DIST_W: if (i_status.div_done) o_cmd.step = STEP_DIST_GET;
            ST_FAR:    o_cmd.step = STEP_FAR;
            ST_IDX:    if (!i_status.far) o_cmd.step = STEP_IDX_GO;
            ST_LOOK:   o_cmd.step = STEP_LOOK;
            ST_MODEL:  o_cmd.step = STEP_MODEL;
            ST_ERR:    o_cmd.step = STEP_ERR;
            ST_SQ:     o_cmd.step = STEP_SQ;
            ST_TERM:   o_cmd.step = i_status.term_sat ? STEP_TERM_SAT : STEP_TERM_GO;
            ST_TERM_W: if (i_status.div_done) o_cmd.step = STEP_TERM_GET;
            ST_OUT:    if (i_status.out_free) o_cmd.step = STEP_OUT;
            default:   o_cmd.step = STEP_NONE;
        endcase
    end

endmodule
